>>> hdl/interior_cell_counter_macros.svh
// Assertion macros for the interior cell counter.
`ifndef INTERIOR_CELL_COUNTER_MACROS_SVH
`define INTERIOR_CELL_COUNTER_MACROS_SVH
`ifndef ASSERT_OFF
`define ICC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ICC_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICC_ASSERT(lbl, prop, msg)
`define ICC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> hdl/icc_pkg.sv
`timescale 1ns / 1ps
package icc_pkg;

	localparam int CFG_AW       = 3;
	localparam int CFG_DW       = 32;
	localparam int REG_ADDR_LSB = 2;
	localparam int SIZE_W       = 7;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
	localparam int COUNT_W      = 13;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;
	localparam int INC_W        = 3;

	typedef enum logic {
		REG_MAP_WIDTH  = 1'b0,
		REG_MAP_HEIGHT = 1'b1
	} reg_idx_t;

	// one line store entry: the row two above and the row just above
	typedef struct packed {
		logic up;
		logic mid;
	} col_t;

	typedef struct packed {
		logic col_ge1;
		logic col_ge2;
		logic row_ge1;
		logic row_ge2;
		logic last_col;
		logic last_row;
	} pos_flags_t;

	// a: row above, b: two rows above, d: current row; l2/l1/c: two left, one left, this column
	typedef struct packed {
		logic a_l2;
		logic a_l1;
		logic a_c;
		logic b_l1;
		logic b_c;
		logic d_l2;
		logic d_l1;
		logic d_c;
	} window_t;

endpackage

>>> hdl/icc_ifs.sv
`timescale 1ns / 1ps
interface icc_cell_if;
	logic valid;
	logic ready;
	logic cell_bit;

	modport source (output valid, output cell_bit, input ready);
	modport sink (input valid, input cell_bit, output ready);
endinterface

interface icc_count_if;
	import icc_pkg::*;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] interior_count;

	modport source (output valid, output interior_count, input ready);
	modport sink (input valid, input interior_count, output ready);
endinterface

>>> hdl/icc_line_store.sv
`timescale 1ns / 1ps
module icc_line_store #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] raddr,
	output icc_pkg::col_t rd_data_q,
	input  logic          wr_en,
	input  logic [AW-1:0] waddr,
	input  icc_pkg::col_t wr_data
);
	import icc_pkg::*;

	col_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wr_data;
		end
	end

	// forward a write to the same column in the same cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (waddr == raddr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[raddr];
			end
		end
	end
endmodule

>>> hdl/icc_judge.sv
`timescale 1ns / 1ps
module icc_judge (
	input  icc_pkg::window_t              win,
	input  icc_pkg::pos_flags_t           pos,
	output logic [icc_pkg::INC_W-1:0]     inc
);
	import icc_pkg::*;

	logic hit_above_left;
	logic hit_above_last;
	logic hit_row_left;
	logic hit_row_last;

	always_comb begin
		hit_above_left = pos.row_ge1 & pos.col_ge1 & win.a_l1 & win.d_l1 & win.a_c
			& (pos.row_ge2 ? win.b_l1 : 1'b1)
			& (pos.col_ge2 ? win.a_l2 : 1'b1);
		hit_above_last = pos.row_ge1 & pos.last_col & win.a_c & win.d_c
			& (pos.row_ge2 ? win.b_c : 1'b1)
			& (pos.col_ge1 ? win.a_l1 : 1'b1);
		hit_row_left = pos.last_row & pos.col_ge1 & win.d_l1 & win.d_c
			& (pos.row_ge1 ? win.a_l1 : 1'b1)
			& (pos.col_ge2 ? win.d_l2 : 1'b1);
		hit_row_last = pos.last_row & pos.last_col & win.d_c
			& (pos.row_ge1 ? win.a_c : 1'b1)
			& (pos.col_ge1 ? win.d_l1 : 1'b1);
		inc = INC_W'(hit_above_left) + INC_W'(hit_above_last)
			+ INC_W'(hit_row_left) + INC_W'(hit_row_last);
	end
endmodule

>>> hdl/interior_cell_counter.sv
// Interior cell counter: takes a binary map one cell per item in row-major order and, after the
// last cell of each frame, gives one item with the number of set cells whose up, down, left and
// right neighbours are all set (neighbours off the map count as set). Map width and height come
// from the two registers (0 reads as 1, values above MAX_WIDTH/MAX_HEIGHT saturate); a write
// restarts the frame. Rate is one cell per clock, set by the single read and single write of the
// two-bit line store per cell; the last cell goes from the stage 1 registers to the result
// register, which presents the count item, and cells keep flowing while it waits, up to the
// last cell of the next frame. The line store needs no clearing after reset.
`timescale 1ns / 1ps
`include "interior_cell_counter_macros.svh"
module interior_cell_counter #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [icc_pkg::CFG_AW-1:0] paddr,
	input  logic [icc_pkg::CFG_DW-1:0] pwdata,
	output logic [icc_pkg::CFG_DW-1:0] prdata,
	output logic                       pready,
	icc_cell_if.sink                   cell_in,
	icc_count_if.source                count_out
);
	import icc_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [SIZE_W-1:0]  map_width_q;
	logic [SIZE_W-1:0]  map_height_q;
	logic [CW-1:0]      w_last;
	logic [RW-1:0]      h_last;
	logic               cfg_we;
	reg_idx_t           reg_sel;

	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	pos_flags_t         pos_in;
	logic               in_acc;

	logic               s1_valid_q;
	logic               bit_s1;
	logic [CW-1:0]      col_s1;
	pos_flags_t         pos_s1;
	col_t               rd_s1;
	col_t               wr_col;
	logic               frame_end_s1;
	logic               s1_go;
	logic               frame_done;

	logic               a_l2_q;
	logic               a_l1_q;
	logic               b_l1_q;
	logic               d_l2_q;
	logic               d_l1_q;
	window_t            win;
	logic [INC_W-1:0]   inc;

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W:0]   count_sum;
	logic [COUNT_W-1:0] count_next;

	logic               out_valid_q;
	logic [COUNT_W-1:0] out_count_q;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite;
	assign reg_sel = reg_idx_t'(paddr[REG_ADDR_LSB]);

	always_comb begin
		unique case (reg_sel)
			REG_MAP_WIDTH:  prdata = CFG_DW'(map_width_q);
			REG_MAP_HEIGHT: prdata = CFG_DW'(map_height_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= SIZE_RESET;
			map_height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			if (reg_sel == REG_MAP_WIDTH) begin
				map_width_q <= pwdata[SIZE_W-1:0];
			end else begin
				map_height_q <= pwdata[SIZE_W-1:0];
			end
		end
	end

	always_comb begin
		if (map_width_q == '0) begin
			w_last = '0;
		end else if (int'(map_width_q) > MAX_WIDTH) begin
			w_last = CW'(MAX_WIDTH - 1);
		end else begin
			w_last = CW'(map_width_q - 1'b1);
		end
		if (map_height_q == '0) begin
			h_last = '0;
		end else if (int'(map_height_q) > MAX_HEIGHT) begin
			h_last = RW'(MAX_HEIGHT - 1);
		end else begin
			h_last = RW'(map_height_q - 1'b1);
		end
	end

	// input side: position of the next cell
	assign in_acc        = cell_in.valid & cell_in.ready;
	assign cell_in.ready = ~s1_valid_q | s1_go;

	always_comb begin
		pos_in.col_ge1  = (col_q != '0);
		pos_in.col_ge2  = (col_q > CW'(1));
		pos_in.row_ge1  = (row_q != '0);
		pos_in.row_ge2  = (row_q > RW'(1));
		pos_in.last_col = (col_q == w_last);
		pos_in.last_row = (row_q == h_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (pos_in.last_col) begin
				col_q <= '0;
				row_q <= pos_in.last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			bit_s1 <= cell_in.cell_bit;
			col_s1 <= col_q;
			pos_s1 <= pos_in;
		end
	end

	assign frame_end_s1 = pos_s1.last_col & pos_s1.last_row;
	assign s1_go        = s1_valid_q & (~frame_end_s1 | ~out_valid_q | count_out.ready);
	assign frame_done   = s1_go & frame_end_s1;

	assign wr_col = '{up: rd_s1.mid, mid: bit_s1};

	icc_line_store #(
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk       (clk),
		.rd_en     (in_acc),
		.raddr     (col_q),
		.rd_data_q (rd_s1),
		.wr_en     (s1_go),
		.waddr     (col_s1),
		.wr_data   (wr_col)
	);

	// shift the neighbour window one column
	always_ff @(posedge clk) begin
		if (s1_go) begin
			a_l2_q <= a_l1_q;
			a_l1_q <= rd_s1.mid;
			b_l1_q <= rd_s1.up;
			d_l2_q <= d_l1_q;
			d_l1_q <= bit_s1;
		end
	end

	assign win = '{
		a_l2: a_l2_q, a_l1: a_l1_q, a_c: rd_s1.mid,
		b_l1: b_l1_q, b_c: rd_s1.up,
		d_l2: d_l2_q, d_l1: d_l1_q, d_c: bit_s1
	};

	icc_judge u_judge (
		.win (win),
		.pos (pos_s1),
		.inc (inc)
	);

	assign count_sum  = {1'b0, count_q} + (COUNT_W + 1)'(inc);
	assign count_next = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= '0;
		end else if (s1_go) begin
			count_q <= frame_end_s1 ? '0 : count_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && frame_end_s1) begin
			out_valid_q <= 1'b1;
		end else if (count_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && frame_end_s1) begin
			out_count_q <= count_next;
		end
	end

	assign count_out.valid          = out_valid_q;
	assign count_out.interior_count = out_count_q;

	`ICC_ASSERT(a_pos_in_map, (col_q <= w_last) && (row_q <= h_last), "position outside map")
	`ICC_ASSERT(a_count_cleared, frame_done |=> count_q == '0, "count not cleared")
	`ICC_ASSERT(a_result_src, $rose(count_out.valid) |-> $past(frame_done), "stray result")
	`ICC_ASSERT_RST(a_stall_at_end, s1_valid_q && !s1_go |-> frame_end_s1 && out_valid_q, "stall")
endmodule
